### rtl/lowest_free_slot_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_unit_macros.svh
// Assertion macros used by the port-level checker of the slot allocator.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define LOWEST_FREE_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFSA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared types and constants of the lowest free slot allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

	// Default geometry of the slot table.
	localparam int LFSA_NUM_SLOTS = 64;
	localparam int LFSA_TIME_BITS = 32;

	// Fixed widths of the port fields.
	localparam int LFSA_FIELD_W      = 32;
	localparam int LFSA_SLOT_FIELD_W = 6;

	// Probe token control that moves from cell to cell.
	typedef struct packed {
		logic active;  // a booking probe sits in this stage
		logic done;    // a lower cell already granted the booking
	} lfsa_tok_t;

	// Top level control state.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} lfsa_state_t;

endpackage

### rtl/lfsa_cell.sv
// ----------------------------------------------------------------------------
// lfsa_cell
// One slot of the allocator: holds the slot's release time and grants the
// passing booking probe when the slot is free and no lower slot took it.
// ----------------------------------------------------------------------------
module lfsa_cell
	import lfsa_pkg::*;
#(
	parameter int TIME_BITS = LFSA_TIME_BITS,
	parameter int SLOT_W    = $clog2(LFSA_NUM_SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [TIME_BITS-1:0] arrival,
	input  logic [TIME_BITS-1:0] depart,
	input  lfsa_tok_t            tok_i,
	input  logic [SLOT_W-1:0]    pos_i,
	input  logic [SLOT_W-1:0]    slot_i,
	output lfsa_tok_t            tok_o,
	output logic [SLOT_W-1:0]    pos_o,
	output logic [SLOT_W-1:0]    slot_o
);

	logic [TIME_BITS-1:0] rel_q;
	lfsa_tok_t            tok_q;
	logic [SLOT_W-1:0]    pos_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 free;
	logic                 grant;

	// The slot is free once its release time is at or below the arrival.
	assign free  = (rel_q <= arrival);
	assign grant = tok_i.active && !tok_i.done && free;

	// Release time and token control; every slot is free after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q        <= '0;
			tok_q.active <= 1'b0;
			tok_q.done   <= 1'b0;
		end else begin
			if (grant) begin
				rel_q <= depart;
			end
			tok_q.active <= tok_i.active;
			tok_q.done   <= tok_i.active && (tok_i.done || free);
		end
	end

	// Position count and granted slot number travel with the token.
	always_ff @(posedge clk) begin
		pos_q  <= pos_i + SLOT_W'(1);
		slot_q <= grant ? pos_i : slot_i;
	end

	assign tok_o  = tok_q;
	assign pos_o  = pos_q;
	assign slot_o = slot_q;

endmodule

### rtl/lowest_free_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_unit
// Grants each booking the lowest-numbered slot whose release time is at or
// below the booking's arrival and stores the departure time in that slot.
// ----------------------------------------------------------------------------
// Usage:
// Bookings enter on the in channel (arrival_time, depart_time) in order of
// arrival. One result per booking leaves on the out channel: slot_index,
// is_target (arrival equals target_arrival) and all_busy (no slot free,
// slot_index then 0, no slot changed). target_arrival is written through the
// cfg channel, which is always ready and should be used while idle.
// A booking is answered by a probe that walks the row of slot cells, one
// cell per cycle, and its result is offered once the probe has left the
// last cell. One booking is in the row at a time: the next one is taken
// only once the probe has left the last cell, so no new booking enters
// the row before the one ahead of it is through with the cell row.
// A result that the receiver stalls waits in the output register; the next
// booking is still taken, and its result waits in a holding register, after
// which input stalls until the output drains.
// Reset frees every slot, clears target_arrival and empties both channels.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator_unit
	import lfsa_pkg::*;
#(
	parameter int NUM_SLOTS = LFSA_NUM_SLOTS,
	parameter int TIME_BITS = LFSA_TIME_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [LFSA_FIELD_W-1:0]      arrival_time,
	input  logic [LFSA_FIELD_W-1:0]      depart_time,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [LFSA_SLOT_FIELD_W-1:0] slot_index,
	output logic                         is_target,
	output logic                         all_busy,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [LFSA_FIELD_W-1:0]      target_arrival
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);

	lfsa_state_t                 state_q;
	logic [LFSA_FIELD_W-1:0]     target_q;
	logic [TIME_BITS-1:0]        arr_q;
	logic [TIME_BITS-1:0]        dep_q;
	logic                        tgt_q;
	logic                        launch_q;
	logic                        out_valid_q;
	logic [LFSA_SLOT_FIELD_W-1:0] out_slot_q;
	logic                        out_tgt_q;
	logic                        out_busy_q;
	logic                        pend_valid_q;
	logic [LFSA_SLOT_FIELD_W-1:0] pend_slot_q;
	logic                        pend_tgt_q;
	logic                        pend_busy_q;

	logic                        in_xfer;
	logic                        out_xfer;
	logic                        tail_load_out;
	logic                        tail_load_pend;
	logic                        pend_to_out;
	logic [LFSA_SLOT_FIELD_W-1:0] res_slot;
	logic [SLOT_W+LFSA_SLOT_FIELD_W-1:0] res_slot_wide;
	logic [TIME_BITS+LFSA_FIELD_W-1:0]   arr_wide;
	logic [TIME_BITS+LFSA_FIELD_W-1:0]   dep_wide;

	lfsa_tok_t                   tok   [NUM_SLOTS+1];
	logic [SLOT_W-1:0]           pos   [NUM_SLOTS+1];
	logic [SLOT_W-1:0]           slot  [NUM_SLOTS+1];

	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid_q && out_ready;
	assign in_ready  = (state_q == ST_IDLE) && !pend_valid_q;
	assign cfg_ready = 1'b1;

	// Times are cut or zero-extended to the internal time width.
	assign arr_wide = {{TIME_BITS{1'b0}}, arrival_time};
	assign dep_wide = {{TIME_BITS{1'b0}}, depart_time};

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			target_q <= target_arrival;
		end
	end

	// Booking register, held while the probe walks the row.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			arr_q <= arr_wide[TIME_BITS-1:0];
			dep_q <= dep_wide[TIME_BITS-1:0];
			tgt_q <= (arrival_time == target_q);
		end
	end

	// Control state: run from input transfer until the probe leaves the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			launch_q <= in_xfer;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tok[NUM_SLOTS].active) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The probe enters the first cell in the cycle after the transfer.
	assign tok[0].active = launch_q;
	assign tok[0].done   = 1'b0;
	assign pos[0]        = '0;
	assign slot[0]       = '0;

	// Row of slot cells.
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		lfsa_cell #(
			.TIME_BITS(TIME_BITS),
			.SLOT_W   (SLOT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.arrival(arr_q),
			.depart (dep_q),
			.tok_i  (tok[i]),
			.pos_i  (pos[i]),
			.slot_i (slot[i]),
			.tok_o  (tok[i+1]),
			.pos_o  (pos[i+1]),
			.slot_o (slot[i+1])
		);
	end

	// The result field carries the low bits of the granted slot number.
	assign res_slot_wide = {{LFSA_SLOT_FIELD_W{1'b0}}, slot[NUM_SLOTS]};
	assign res_slot      = res_slot_wide[LFSA_SLOT_FIELD_W-1:0];

	// Result steering between the output and the holding register.
	assign tail_load_out  = tok[NUM_SLOTS].active && (!out_valid_q || out_ready);
	assign tail_load_pend = tok[NUM_SLOTS].active && out_valid_q && !out_ready;
	assign pend_to_out    = !tok[NUM_SLOTS].active && pend_valid_q &&
	                        (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (tail_load_out || pend_to_out) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			if (tail_load_pend) begin
				pend_valid_q <= 1'b1;
			end else if (pend_to_out) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (tail_load_out) begin
			out_slot_q <= res_slot;
			out_tgt_q  <= tgt_q;
			out_busy_q <= !tok[NUM_SLOTS].done;
		end else if (pend_to_out) begin
			out_slot_q <= pend_slot_q;
			out_tgt_q  <= pend_tgt_q;
			out_busy_q <= pend_busy_q;
		end
		if (tail_load_pend) begin
			pend_slot_q <= res_slot;
			pend_tgt_q  <= tgt_q;
			pend_busy_q <= !tok[NUM_SLOTS].done;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_index = out_slot_q;
	assign is_target  = out_tgt_q;
	assign all_busy   = out_busy_q;

endmodule

### rtl/lfsa_checker.sv
// ----------------------------------------------------------------------------
// lfsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "lowest_free_slot_allocator_unit_macros.svh"

module lfsa_checker
	import lfsa_pkg::*;
(
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [LFSA_SLOT_FIELD_W-1:0] slot_index,
	input logic                         is_target,
	input logic                         all_busy
);

	// A stalled result stays offered.
	`LFSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped")

	// A stalled result keeps its payload.
	`LFSA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(slot_index) && $stable(is_target) && $stable(all_busy), "stalled result changed")

	// A booking that found no free slot reports slot zero.
	`LFSA_ASSERT_SAME(a_busy_slot, out_valid && all_busy, slot_index == '0, "slot set while all busy")

	// Input is never taken twice in a row.
	`LFSA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken twice in a row")

endmodule

bind lowest_free_slot_allocator_unit lfsa_checker u_lfsa_checker (.*);

### test/lowest_free_slot_allocator_unit_checker.sv
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_unit_checker
// Watches the booking, result and register channels of the slot allocator,
// keeps its own slot table to work out each booking's grant and compares
// every result transfer against the oldest open booking.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator_unit_checker
	import lfsa_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [LFSA_FIELD_W-1:0]      arrival_time,
	input  logic [LFSA_FIELD_W-1:0]      depart_time,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [LFSA_SLOT_FIELD_W-1:0] slot_index,
	input  logic                         is_target,
	input  logic                         all_busy,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [LFSA_FIELD_W-1:0]      target_arrival,
	output int                           mismatches,
	output int                           bookings_open
);
	timeunit 1ns;
	timeprecision 1ps;

	// One result transfer as the allocator should present it.
	typedef struct packed {
		logic [LFSA_SLOT_FIELD_W-1:0] slot;
		logic                         hit;
		logic                         busy;
	} booking_result_t;

	logic [LFSA_TIME_BITS-1:0] release_at [LFSA_NUM_SLOTS];
	logic [LFSA_FIELD_W-1:0]   target_copy;
	booking_result_t           awaited_grants [$];

	// Grant the lowest slot whose release time is at or below the arrival and
	// book it until the departure time. With no free slot the table stays as it is.
	function automatic booking_result_t book_lowest_slot(
		input logic [LFSA_FIELD_W-1:0] arr,
		input logic [LFSA_FIELD_W-1:0] dep
	);
		booking_result_t grant;
		grant.slot = '0;
		grant.hit  = (arr == target_copy);
		grant.busy = 1'b1;
		for (int s = 0; s < LFSA_NUM_SLOTS; s++) begin
			if (grant.busy && release_at[s] <= arr[LFSA_TIME_BITS-1:0]) begin
				release_at[s] = dep[LFSA_TIME_BITS-1:0];
				grant.slot    = LFSA_SLOT_FIELD_W'(s);
				grant.busy    = 1'b0;
			end
		end
		return grant;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		booking_result_t want;
		booking_result_t got;
		if (!arst_n) begin
			foreach (release_at[s])
				release_at[s] = '0;
			target_copy = '0;
			awaited_grants.delete();
			mismatches = 0;
			bookings_open <= 0;
		end else begin
			// Register writes only happen while no booking is open.
			if (cfg_valid && cfg_ready) begin
				target_copy = target_arrival;
			end

			// Each result transfer must match the oldest open booking.
			if (out_valid && out_ready) begin
				got.slot = slot_index;
				got.hit  = is_target;
				got.busy = all_busy;
				if (awaited_grants.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result with no open booking: slot %0d is_target %0b all_busy %0b",
							$realtime, got.slot, got.hit, got.busy);
					end
				end else begin
					want = awaited_grants.pop_front();
					if (got.slot !== want.slot || got.hit !== want.hit ||
							got.busy !== want.busy) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: booking result differs: expected slot %0d is_target %0b all_busy %0b, got slot %0d is_target %0b all_busy %0b",
								$realtime, want.slot, want.hit, want.busy,
								got.slot, got.hit, got.busy);
						end
					end
				end
			end

			// A booking transfer updates the table and opens one expected result.
			if (in_valid && in_ready) begin
				awaited_grants.push_back(book_lowest_slot(arrival_time, depart_time));
			end

			bookings_open <= awaited_grants.size();
		end
	end

endmodule

### test/tb_lowest_free_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_lowest_free_slot_allocator_unit
// Drives bookings into the slot allocator, first a few hand-picked ones and
// then phases of random bursts with overlapping stays, each phase under its
// own target arrival and one of four mixes of sender gaps and receiver stalls.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lowest_free_slot_allocator_unit;
	import lfsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_COUNT      = 6;
	localparam int BOOKINGS_PER_PHASE = 280;
	localparam int HOLD_CYCLES      = 600;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [LFSA_FIELD_W-1:0]      arrival_time;
	logic [LFSA_FIELD_W-1:0]      depart_time;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [LFSA_SLOT_FIELD_W-1:0] slot_index;
	logic                         is_target;
	logic                         all_busy;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [LFSA_FIELD_W-1:0]      target_arrival;

	int mismatches;
	int bookings_open;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int holds_served;
	int hold_left;

	always #10 clk = ~clk;

	lowest_free_slot_allocator_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.arrival_time   (arrival_time),
		.depart_time    (depart_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.slot_index     (slot_index),
		.is_target      (is_target),
		.all_busy       (all_busy),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.target_arrival (target_arrival)
	);

	lowest_free_slot_allocator_unit_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.arrival_time   (arrival_time),
		.depart_time    (depart_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.slot_index     (slot_index),
		.is_target      (is_target),
		.all_busy       (all_busy),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.target_arrival (target_arrival),
		.mismatches     (mismatches),
		.bookings_open  (bookings_open)
	);

	// Offer one booking after a random gap and hold it until the transfer.
	task automatic send_booking(input logic [LFSA_FIELD_W-1:0] arr,
			input logic [LFSA_FIELD_W-1:0] dep);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		arrival_time <= arr;
		depart_time  <= dep;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every open booking has its result.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (bookings_open != 0);
	endtask

	// Receiver: random stalls, plus a long hold-off when one is requested so
	// that the block backs up and stops taking bookings.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready    <= 1'b0;
			hold_left    <= 0;
			holds_served <= 0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			holds_served <= hold_requests;
			hold_left    <= HOLD_CYCLES;
			out_ready    <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Stimulus.
	initial begin
		logic [LFSA_FIELD_W-1:0] now_t;
		logic [LFSA_FIELD_W-1:0] tgt;
		logic [LFSA_FIELD_W-1:0] arr;
		logic [LFSA_FIELD_W-1:0] dep;
		int                      pick;
		int                      span;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		arrival_time   = '0;
		depart_time    = '0;
		cfg_valid      = 1'b0;
		target_arrival = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-picked bookings under the reset target of zero: reuse of a slot
		// released exactly at arrival, departure before arrival, an arrival
		// out of order and the largest times.
		send_booking(32'd0, 32'd0);
		send_booking(32'd0, 32'd10);
		send_booking(32'd0, 32'd10);
		send_booking(32'd0, 32'd0);
		send_booking(32'd0, 32'd5);
		send_booking(32'd5, 32'd20);
		send_booking(32'd10, 32'd3);
		send_booking(32'd10, 32'd12);
		send_booking(32'd2, 32'd4);
		send_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_booking(32'hFFFF_FFFF, 32'd0);
		send_booking(32'hFFFF_FFFF, 32'd0);
		send_booking(32'hAAAA_AAAA, 32'h5555_5555);
		send_booking(32'h5555_5555, 32'd0);

		// Random phases: time climbs from phase to phase so that the high bits
		// of every time field get exercised without wrapping around.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			wait_drained();
			now_t = 32'(phase) * 32'h2800_0000 + $urandom_range(0, 32'h00FF_FFFF);
			case (phase)
				0: tgt = '1;
				1: tgt = '0;
				default: tgt = now_t + $urandom_range(0, 40);
			endcase

			// Register write while the block is idle.
			cfg_valid      <= 1'b1;
			target_arrival <= tgt;
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;

			case (phase)
				0, 4: begin
					idle_pct  = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct  = 65;
					stall_pct <= 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct <= 65;
				end
				default: begin
					idle_pct  = 38;
					stall_pct <= 38;
				end
			endcase

			for (int n = 0; n < BOOKINGS_PER_PHASE; n++) begin
				if (phase == 2 && n == 30) begin
					hold_requests <= hold_requests + 1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					// Arrival right on the target.
					arr = tgt;
					dep = arr + $urandom_range(0, 100);
				end else if (pick < 9) begin
					// Arrival earlier than the running time.
					arr = now_t - $urandom_range(1, 300);
					dep = arr + $urandom_range(0, 50);
				end else if (pick < 10) begin
					arr = $urandom();
					dep = $urandom();
				end else begin
					// Well-formed burst: small steps and overlapping stays fill
					// the table; an occasional long gap empties it again.
					if ($urandom_range(0, 39) == 0) begin
						now_t = now_t + $urandom_range(1000, 32'h000F_FFFF);
					end
					span = $urandom_range(0, 9);
					if (span >= 8) begin
						now_t = now_t + $urandom_range(2, 6);
					end else if (span >= 5) begin
						now_t = now_t + 1;
					end
					arr  = now_t;
					span = $urandom_range(0, 19);
					if (span == 0) begin
						dep = arr - $urandom_range(0, 100);
					end else if (span <= 6) begin
						dep = arr + $urandom_range(0, 10);
					end else if (span <= 17) begin
						dep = arr + $urandom_range(20, 120);
					end else begin
						dep = arr + $urandom_range(200, 1500);
					end
				end
				send_booking(arr, dep);
			end
		end

		wait_drained();
		repeat (LFSA_NUM_SLOTS + 8) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#30_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/lfsa_pkg.sv
rtl/lfsa_cell.sv
rtl/lowest_free_slot_allocator_unit.sv
rtl/lfsa_checker.sv
test/lowest_free_slot_allocator_unit_checker.sv
test/tb_lowest_free_slot_allocator_unit.sv
